/* rtl/ecpa_pkg.sv */
// ----------------------------------------------------------------------------
// ecpa_pkg
// shared constants, types and codes for the prime field point adder
// ----------------------------------------------------------------------------
`default_nettype none
package ecpa_pkg;
   localparam int CoordWidth = 16;
   localparam int CsrAddrWidth = 2;
   localparam logic [CoordWidth-1:0] ModulusReset = CoordWidth'(29);
   localparam logic [CsrAddrWidth-1:0] RegModulus = '0;

   typedef logic [CoordWidth-1:0] coord_type;

   // datapath operations
   typedef logic [3:0] op_type;
   localparam op_type OP_NONE    = 4'd0;
   localparam op_type OP_LOAD    = 4'd1;  // latch raw inputs
   localparam op_type OP_RED     = 4'd2;  // reduce one operand bit-serially
   localparam op_type OP_MUL     = 4'd3;  // dst = a*b mod m, bit-serial
   localparam op_type OP_ADD     = 4'd4;  // dst = a+b mod m
   localparam op_type OP_SUB     = 4'd5;  // dst = a-b mod m
   localparam op_type OP_DIV     = 4'd6;  // euclid division r0/r1, bit-serial
   localparam op_type OP_EUSTEP  = 4'd7;  // euclid rotate after mul
   localparam op_type OP_INIT_EU = 4'd8;

   // operand select codes
   typedef logic [3:0] sel_type;
   localparam sel_type S_PX  = 4'd0;
   localparam sel_type S_PY  = 4'd1;
   localparam sel_type S_QX  = 4'd2;
   localparam sel_type S_QY  = 4'd3;
   localparam sel_type S_NUM = 4'd4;
   localparam sel_type S_DEN = 4'd5;
   localparam sel_type S_LAM = 4'd6;
   localparam sel_type S_RX  = 4'd7;
   localparam sel_type S_RY  = 4'd8;
   localparam sel_type S_ACC = 4'd9;
   localparam sel_type S_T1  = 4'd10;
   localparam sel_type S_Q   = 4'd11;
   localparam sel_type S_T0  = 4'd12;
   localparam sel_type S_TMP = 4'd13;

   typedef struct packed {
      op_type  op;
      sel_type sel_a;
      sel_type sel_b;
      sel_type dst;
      logic    start;  // first cycle of a multi-cycle op
   } cmd_type;

   typedef struct packed {
      logic busy;      // multi-cycle op running
      logic r1_zero;
      logic r0_one;
      logic pt_equal;
      logic mod_small;
   } stat_type;
endpackage
`default_nettype wire

/* rtl/ecpa_if.sv */
// ----------------------------------------------------------------------------
// ecpa_req_if / ecpa_rsp_if
// valid/ready channels for the point adder
// ----------------------------------------------------------------------------
`default_nettype none
interface ecpa_req_if;
   logic valid;
   logic ready;
   logic [ecpa_pkg::CoordWidth-1:0] p_x, p_y, q_x, q_y;
   modport source (output valid, p_x, p_y, q_x, q_y, input ready);
   modport sink (input valid, p_x, p_y, q_x, q_y, output ready);
endinterface

interface ecpa_rsp_if;
   logic valid;
   logic ready;
   logic [ecpa_pkg::CoordWidth-1:0] r_x, r_y;
   logic status;
   modport source (output valid, r_x, r_y, status, input ready);
   modport sink (input valid, r_x, r_y, status, output ready);
endinterface
`default_nettype wire

/* rtl/ecpa_datapath.sv */
// ----------------------------------------------------------------------------
// ecpa_datapath
// register file with bit-serial modular multiply, reduce and divide units
// ----------------------------------------------------------------------------
`default_nettype none
module ecpa_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ecpa_pkg::cmd_type cmd,
   input  wire ecpa_pkg::coord_type modulus,
   input  wire ecpa_pkg::coord_type in_px,
   input  wire ecpa_pkg::coord_type in_py,
   input  wire ecpa_pkg::coord_type in_qx,
   input  wire ecpa_pkg::coord_type in_qy,
   output ecpa_pkg::stat_type     stat,
   output ecpa_pkg::coord_type    rx,
   output ecpa_pkg::coord_type    ry
);
   import ecpa_pkg::*;
   localparam int W = CoordWidth;
   localparam int CntW = $clog2(W + 1);

   coord_type px_ff, py_ff, qx_ff, qy_ff, num_ff, den_ff, lam_ff, rx_ff, ry_ff;
   coord_type acc_ff, t0_ff, t1_ff, q_ff, tmp_ff, r0_ff, r1_ff;
   coord_type px_in, py_in, qx_in, qy_in, num_in, den_in, lam_in, rx_in, ry_in;
   coord_type acc_in, t0_in, t1_in, q_in, tmp_in, r0_in, r1_in;
   // serial unit state
   coord_type sa_ff, sa_in, sb_ff, sb_in, rem_ff, rem_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   op_type sop_ff, sop_in;
   sel_type sdst_ff, sdst_in;

   coord_type opa, opb, wres;
   logic wen;
   logic [W:0] sum_w, dbl_w, rsh;

   function automatic coord_type pick(sel_type s, coord_type vpx, coord_type vpy,
         coord_type vqx, coord_type vqy, coord_type vnum, coord_type vden,
         coord_type vlam, coord_type vrx, coord_type vry, coord_type vacc,
         coord_type vt1, coord_type vq, coord_type vt0, coord_type vtmp);
      case (s)
         S_PX: pick = vpx;
         S_PY: pick = vpy;
         S_QX: pick = vqx;
         S_QY: pick = vqy;
         S_NUM: pick = vnum;
         S_DEN: pick = vden;
         S_LAM: pick = vlam;
         S_RX: pick = vrx;
         S_RY: pick = vry;
         S_ACC: pick = vacc;
         S_T1: pick = vt1;
         S_Q: pick = vq;
         S_T0: pick = vt0;
         S_TMP: pick = vtmp;
         default: pick = '0;
      endcase
   endfunction

   function automatic coord_type addm(coord_type a, coord_type b, coord_type m);
      logic [W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, m}) addm = W'(s - {1'b0, m});
      else addm = W'(s);
   endfunction

   function automatic coord_type subm(coord_type a, coord_type b, coord_type m);
      if (a >= b) subm = a - b;
      else subm = m - (b - a);
   endfunction

   always_comb begin
      opa = pick(cmd.sel_a, px_ff, py_ff, qx_ff, qy_ff, num_ff, den_ff, lam_ff,
                 rx_ff, ry_ff, acc_ff, t1_ff, q_ff, t0_ff, tmp_ff);
      opb = pick(cmd.sel_b, px_ff, py_ff, qx_ff, qy_ff, num_ff, den_ff, lam_ff,
                 rx_ff, ry_ff, acc_ff, t1_ff, q_ff, t0_ff, tmp_ff);
   end

   // shift-subtract step shared by reduce and divide
   assign rsh = {rem_ff, sa_ff[W-1]};

   always_comb begin
      px_in = px_ff; py_in = py_ff; qx_in = qx_ff; qy_in = qy_ff;
      num_in = num_ff; den_in = den_ff; lam_in = lam_ff; rx_in = rx_ff;
      ry_in = ry_ff; acc_in = acc_ff; t0_in = t0_ff; t1_in = t1_ff;
      q_in = q_ff; tmp_in = tmp_ff; r0_in = r0_ff; r1_in = r1_ff;
      sa_in = sa_ff; sb_in = sb_ff; rem_in = rem_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; sop_in = sop_ff; sdst_in = sdst_ff;
      wen = 1'b0; wres = '0;
      sum_w = '0; dbl_w = '0;
      if (busy_ff) begin
         case (sop_ff)
            OP_MUL: begin
               // msb-first double and add on sb bits
               dbl_w = {1'b0, addm(rem_ff, rem_ff, modulus)};
               if (sb_ff[W-1]) rem_in = addm(W'(dbl_w), sa_ff, modulus);
               else rem_in = W'(dbl_w);
               sb_in = sb_ff << 1;
            end
            OP_RED, OP_DIV: begin
               // restoring division of sa by sb
               if (rsh >= {1'b0, sb_ff}) begin
                  sum_w = rsh - {1'b0, sb_ff};
                  rem_in = W'(sum_w);
                  sa_in = {sa_ff[W-2:0], 1'b1};
               end else begin
                  rem_in = W'(rsh);
                  sa_in = {sa_ff[W-2:0], 1'b0};
               end
            end
            default: ;
         endcase
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            if (sop_ff == OP_DIV) begin
               // quotient to q, remainder rotates into r1
               q_in = (rsh >= {1'b0, sb_ff}) ? {sa_ff[W-2:0], 1'b1}
                                              : {sa_ff[W-2:0], 1'b0};
               r0_in = r1_ff;
               r1_in = (rsh >= {1'b0, sb_ff}) ? W'(rsh - {1'b0, sb_ff}) : W'(rsh);
            end else begin
               wen = 1'b1;
               wres = rem_in;
            end
         end
      end else begin
         case (cmd.op)
            OP_LOAD: begin
               px_in = in_px; py_in = in_py; qx_in = in_qx; qy_in = in_qy;
            end
            OP_RED: begin
               busy_in = 1'b1; sop_in = OP_RED; sdst_in = cmd.dst;
               sa_in = opa; sb_in = modulus; rem_in = '0; cnt_in = CntW'(W);
            end
            OP_DIV: begin
               busy_in = 1'b1; sop_in = OP_DIV;
               sa_in = r0_ff; sb_in = r1_ff; rem_in = '0; cnt_in = CntW'(W);
            end
            OP_MUL: begin
               busy_in = 1'b1; sop_in = OP_MUL; sdst_in = cmd.dst;
               sa_in = opa; sb_in = opb; rem_in = '0; cnt_in = CntW'(W);
            end
            OP_ADD: begin wen = 1'b1; wres = addm(opa, opb, modulus); end
            OP_SUB: begin wen = 1'b1; wres = subm(opa, opb, modulus); end
            OP_INIT_EU: begin
               r0_in = modulus; r1_in = opa; t0_in = '0; t1_in = W'(1);
            end
            OP_EUSTEP: begin
               // t2 = t0 - q*t1, q*t1 already in acc
               t0_in = t1_ff; t1_in = subm(t0_ff, acc_ff, modulus);
            end
            default: ;
         endcase
      end
      if (wen) begin
         case (busy_ff ? sdst_ff : cmd.dst)
            S_PX: px_in = wres;
            S_PY: py_in = wres;
            S_QX: qx_in = wres;
            S_QY: qy_in = wres;
            S_NUM: num_in = wres;
            S_DEN: den_in = wres;
            S_LAM: lam_in = wres;
            S_RX: rx_in = wres;
            S_RY: ry_in = wres;
            S_ACC: acc_in = wres;
            S_Q: q_in = wres;
            S_TMP: tmp_in = wres;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      px_ff <= px_in; py_ff <= py_in; qx_ff <= qx_in; qy_ff <= qy_in;
      num_ff <= num_in; den_ff <= den_in; lam_ff <= lam_in; rx_ff <= rx_in;
      ry_ff <= ry_in; acc_ff <= acc_in; t0_ff <= t0_in; t1_ff <= t1_in;
      q_ff <= q_in; tmp_ff <= tmp_in; r0_ff <= r0_in; r1_ff <= r1_in;
      sa_ff <= sa_in; sb_ff <= sb_in; rem_ff <= rem_in;
      sop_ff <= sop_in; sdst_ff <= sdst_in;
   end

   assign stat.busy = busy_ff;
   assign stat.r1_zero = (r1_ff == '0);
   assign stat.r0_one = (r0_ff == W'(1));
   assign stat.pt_equal = (px_ff == qx_ff) && (py_ff == qy_ff);
   assign stat.mod_small = (modulus < W'(2));
   assign rx = rx_ff;
   assign ry = ry_ff;
endmodule
`default_nettype wire

/* rtl/ecpa_ctrl.sv */
// ----------------------------------------------------------------------------
// ecpa_ctrl
// microcode sequencer issuing datapath commands for one point addition
// ----------------------------------------------------------------------------
`default_nettype none
module ecpa_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_inf,
   input  wire ecpa_pkg::stat_type stat,
   output ecpa_pkg::cmd_type       cmd
);
   import ecpa_pkg::*;

   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_RPX = 5'd1;
   localparam logic [4:0] ST_RPY = 5'd2;
   localparam logic [4:0] ST_RQX = 5'd3;
   localparam logic [4:0] ST_RQY = 5'd4;
   localparam logic [4:0] ST_SEL = 5'd5;
   localparam logic [4:0] ST_XX = 5'd6;
   localparam logic [4:0] ST_X2 = 5'd7;
   localparam logic [4:0] ST_X3 = 5'd8;
   localparam logic [4:0] ST_Y2 = 5'd9;
   localparam logic [4:0] ST_SN = 5'd10;
   localparam logic [4:0] ST_SD = 5'd11;
   localparam logic [4:0] ST_EI = 5'd12;
   localparam logic [4:0] ST_EC = 5'd13;
   localparam logic [4:0] ST_ED = 5'd14;
   localparam logic [4:0] ST_EM = 5'd15;
   localparam logic [4:0] ST_ES = 5'd16;
   localparam logic [4:0] ST_LAM = 5'd17;
   localparam logic [4:0] ST_LL = 5'd18;
   localparam logic [4:0] ST_S1 = 5'd19;
   localparam logic [4:0] ST_S2 = 5'd20;
   localparam logic [4:0] ST_S3 = 5'd21;
   localparam logic [4:0] ST_M4 = 5'd22;
   localparam logic [4:0] ST_S4 = 5'd23;
   localparam logic [4:0] ST_OUT = 5'd24;

   logic [4:0] state_ff, state_in;
   logic inf_ff, inf_in, wait_ff, wait_in;

   always_comb begin
      state_in = state_ff;
      inf_in = inf_ff;
      wait_in = 1'b0;
      cmd = '{op: OP_NONE, sel_a: S_PX, sel_b: S_PX, dst: S_ACC, start: 1'b0};
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      // a multi-cycle op is issued once, then wait for busy to drop
      if (wait_ff || stat.busy) begin
         wait_in = 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               req_ready = 1'b1;
               if (req_valid) begin
                  cmd.op = OP_LOAD;
                  state_in = ST_RPX;
               end
            end
            ST_RPX: begin
               if (stat.mod_small) begin
                  inf_in = 1'b1; state_in = ST_OUT;
               end else begin
                  cmd = '{OP_RED, S_PX, S_PX, S_PX, 1'b1}; wait_in = 1'b1;
                  state_in = ST_RPY;
               end
            end
            ST_RPY: begin cmd = '{OP_RED, S_PY, S_PX, S_PY, 1'b1}; wait_in = 1'b1;
               state_in = ST_RQX; end
            ST_RQX: begin cmd = '{OP_RED, S_QX, S_PX, S_QX, 1'b1}; wait_in = 1'b1;
               state_in = ST_RQY; end
            ST_RQY: begin cmd = '{OP_RED, S_QY, S_PX, S_QY, 1'b1}; wait_in = 1'b1;
               state_in = ST_SEL; end
            ST_SEL: state_in = stat.pt_equal ? ST_XX : ST_SN;
            ST_XX: begin cmd = '{OP_MUL, S_PX, S_PX, S_TMP, 1'b1}; wait_in = 1'b1;
               state_in = ST_X2; end
            ST_X2: begin cmd = '{OP_ADD, S_TMP, S_TMP, S_NUM, 1'b0}; state_in = ST_X3; end
            ST_X3: begin cmd = '{OP_ADD, S_NUM, S_TMP, S_NUM, 1'b0}; state_in = ST_Y2; end
            ST_Y2: begin cmd = '{OP_ADD, S_PY, S_PY, S_DEN, 1'b0}; state_in = ST_EI; end
            ST_SN: begin cmd = '{OP_SUB, S_QY, S_PY, S_NUM, 1'b0}; state_in = ST_SD; end
            ST_SD: begin cmd = '{OP_SUB, S_QX, S_PX, S_DEN, 1'b0}; state_in = ST_EI; end
            ST_EI: begin cmd = '{OP_INIT_EU, S_DEN, S_DEN, S_ACC, 1'b0}; state_in = ST_EC; end
            ST_EC: begin
               if (stat.r1_zero) begin
                  if (stat.r0_one) state_in = ST_LAM;
                  else begin inf_in = 1'b1; state_in = ST_OUT; end
               end else state_in = ST_ED;
            end
            ST_ED: begin cmd = '{OP_DIV, S_PX, S_PX, S_Q, 1'b1}; wait_in = 1'b1;
               state_in = ST_EM; end
            // q stays below m except on the first step with den = 1, where q = m
            // and the multiply still gives 0, so q needs no reduction
            ST_EM: begin cmd = '{OP_MUL, S_Q, S_T1, S_ACC, 1'b1}; wait_in = 1'b1;
               state_in = ST_ES; end
            ST_ES: begin cmd.op = OP_EUSTEP; state_in = ST_EC; end
            ST_LAM: begin cmd = '{OP_MUL, S_NUM, S_T0, S_LAM, 1'b1}; wait_in = 1'b1;
               state_in = ST_LL; end
            ST_LL: begin cmd = '{OP_MUL, S_LAM, S_LAM, S_TMP, 1'b1}; wait_in = 1'b1;
               state_in = ST_S1; end
            ST_S1: begin cmd = '{OP_SUB, S_TMP, S_PX, S_TMP, 1'b0}; state_in = ST_S2; end
            ST_S2: begin cmd = '{OP_SUB, S_TMP, S_QX, S_RX, 1'b0}; state_in = ST_S3; end
            ST_S3: begin cmd = '{OP_SUB, S_PX, S_RX, S_TMP, 1'b0}; state_in = ST_M4; end
            ST_M4: begin cmd = '{OP_MUL, S_LAM, S_TMP, S_TMP, 1'b1}; wait_in = 1'b1;
               state_in = ST_S4; end
            ST_S4: begin cmd = '{OP_SUB, S_TMP, S_PY, S_RY, 1'b0}; inf_in = 1'b0;
               state_in = ST_OUT; end
            ST_OUT: begin
               rsp_valid = 1'b1;
               if (rsp_ready) state_in = ST_IDLE;
            end
            default: state_in = ST_IDLE;
         endcase
         if (state_ff == ST_IDLE) inf_in = 1'b0;
         if (state_ff == ST_S4) inf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         inf_ff <= 1'b0;
         wait_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         inf_ff <= inf_in;
         wait_ff <= wait_in;
      end
   end

   assign rsp_inf = inf_ff;
endmodule
`default_nettype wire

/* rtl/ec_point_add_prime_field.sv */
// ----------------------------------------------------------------------------
// ec_point_add_prime_field
// affine point addition / doubling on y^2 = x^3 + b over GF(p)
// ----------------------------------------------------------------------------
//  channel  dir  handshake       word
//  req      in   valid/ready     p_x p_y q_x q_y
//  rsp      out  valid/ready     r_x r_y status
//  csr      in   apb write/read  modulus at 0x0
//
//  one word at a time; reduce, multiply and divide are bit-serial, and an
//  addition or a doubling runs one euclid inversion of its denominator
//  a modulus below two skips the arithmetic and answers with infinity
//  reset puts the modulus at 29 and the sequencer idle
//  the result holds in its register while rsp_ready is low
`default_nettype none
module ec_point_add_prime_field (
   input  wire logic clock,
   input  wire logic reset,
   ecpa_req_if.sink  req,
   ecpa_rsp_if.source rsp,
   input  wire logic csr_psel,
   input  wire logic csr_penable,
   input  wire logic csr_pwrite,
   input  wire logic [ecpa_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   import ecpa_pkg::*;

   coord_type modulus_ff, modulus_in;
   cmd_type cmd;
   stat_type stat;
   coord_type rx, ry;
   logic inf;

   // modulus register, written on the apb access phase
   always_comb begin
      modulus_in = modulus_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr == RegModulus)
         modulus_in = csr_pwdata[CoordWidth-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) modulus_ff <= ModulusReset;
      else modulus_ff <= modulus_in;
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == RegModulus) ? 32'(modulus_ff) : '0;

   ecpa_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_inf(inf),
      .stat(stat), .cmd(cmd)
   );

   ecpa_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .modulus(modulus_ff),
      .in_px(req.p_x), .in_py(req.p_y), .in_qx(req.q_x), .in_qy(req.q_y),
      .stat(stat), .rx(rx), .ry(ry)
   );

   // infinity forces zero coordinates
   assign rsp.r_x = inf ? '0 : rx;
   assign rsp.r_y = inf ? '0 : ry;
   assign rsp.status = inf;
endmodule
`default_nettype wire

/* rtl/ecpa_checker.sv */
// ----------------------------------------------------------------------------
// ecpa_checker
// port-level checks on the point adder
// ----------------------------------------------------------------------------
`default_nettype none
module ecpa_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_status,
   input wire logic [ecpa_pkg::CoordWidth-1:0] rsp_r_x,
   input wire logic [ecpa_pkg::CoordWidth-1:0] rsp_r_y
);
   // one word in flight: no new word while a result is offered
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("accept while result pending");
   // accepted word gives no result in the next cycle
   a_lat: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid) else $error("result too early");
   // infinity carries zero coordinates
   a_inf: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_r_x == '0 && rsp_r_y == '0))
      else $error("infinity with coordinates");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_r_x)))
      else $error("stalled result changed");
endmodule

bind ec_point_add_prime_field ecpa_checker u_chk (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_status(rsp.status),
   .rsp_r_x(rsp.r_x), .rsp_r_y(rsp.r_y)
);
`default_nettype wire
